/* sv/bc45_pkg.sv */
// Shared types, constants and divide helpers for the BC4/BC5 block decoder.
`timescale 1ns / 1ps

package bc45_pkg;

  localparam int unsigned PixelsPerBlock = 16;
  localparam int unsigned IndexBits      = 3;
  localparam int unsigned IndexWordBits  = 48;
  localparam int unsigned HalfBits       = 64;
  localparam int unsigned ValueBits      = 8;
  localparam int unsigned PixNumBits     = 4;

  localparam logic [PixNumBits-1:0] LastPixel = 4'd15;
  localparam logic [ValueBits-1:0]  ValueMax  = 8'd255;
  localparam logic [ValueBits-1:0]  ValueMin  = 8'd0;

  // Mode register reset value: two channel red/green
  localparam logic ModeReset = 1'b1;

  // Eight palette entries of one channel
  typedef logic [7:0][ValueBits-1:0] palette_t;

  // One decoded pixel as it leaves the block
  typedef struct packed {
    logic [ValueBits-1:0]  red_value;
    logic [ValueBits-1:0]  green_value;
    logic [ValueBits-1:0]  blue_value;
    logic [PixNumBits-1:0] pixel_number;
    logic                  last_pixel;
  } pixel_t;

  // Floor of x / 7 for x below 1792: multiply by 4682 / 2^15
  function automatic logic [ValueBits-1:0] div7(input logic [10:0] x);
    logic [25:0] prod;
    prod = 26'(x) * 26'd4682;
    return prod[22:15];
  endfunction

  // Floor of x / 5 for x below 1280: multiply by 3277 / 2^14
  function automatic logic [ValueBits-1:0] div5(input logic [10:0] x);
    logic [25:0] prod;
    prod = 26'(x) * 26'd3277;
    return prod[21:14];
  endfunction

endpackage

/* sv/bc45_if.sv */
// Valid/ready channel interfaces for compressed blocks and decoded pixels.
`timescale 1ns / 1ps

interface bc45_in_if;
  logic                                valid;
  logic                                ready;
  logic [bc45_pkg::HalfBits-1:0]       first_half;
  logic [bc45_pkg::HalfBits-1:0]       second_half;

  modport source (output valid, first_half, second_half, input ready);
  modport sink   (input valid, first_half, second_half, output ready);
endinterface

interface bc45_out_if;
  logic                                valid;
  logic                                ready;
  logic [bc45_pkg::ValueBits-1:0]      red_value;
  logic [bc45_pkg::ValueBits-1:0]      green_value;
  logic [bc45_pkg::ValueBits-1:0]      blue_value;
  logic [bc45_pkg::PixNumBits-1:0]     pixel_number;
  logic                                last_pixel;

  modport source (output valid, red_value, green_value, blue_value, pixel_number,
                  last_pixel, input ready);
  modport sink   (input valid, red_value, green_value, blue_value, pixel_number,
                  last_pixel, output ready);
endinterface

/* sv/bc45_palette.sv */
// Builds the eight-entry palette of one channel from its two endpoints.
`timescale 1ns / 1ps

module bc45_palette (
  input  logic [bc45_pkg::ValueBits-1:0] ep0_i,
  input  logic [bc45_pkg::ValueBits-1:0] ep1_i,
  output bc45_pkg::palette_t             palette_o
);

  logic [10:0] num7 [6];
  logic [10:0] num5 [4];

  // Weighted endpoint sums for sevenths and fifths
  always_comb begin
    for (int k = 1; k <= 6; k++) begin
      num7[k-1] = 11'(ep0_i) * 11'(7 - k) + 11'(ep1_i) * 11'(k);
    end
    for (int k = 1; k <= 4; k++) begin
      num5[k-1] = 11'(ep0_i) * 11'(5 - k) + 11'(ep1_i) * 11'(k);
    end
  end

  // Pick sevenths when endpoint0 is larger, else fifths plus black and white
  always_comb begin
    palette_o[0] = ep0_i;
    palette_o[1] = ep1_i;
    if (ep0_i > ep1_i) begin
      for (int k = 0; k < 6; k++) begin
        palette_o[k+2] = bc45_pkg::div7(num7[k]);
      end
    end else begin
      for (int k = 0; k < 4; k++) begin
        palette_o[k+2] = bc45_pkg::div5(num5[k]);
      end
      palette_o[6] = bc45_pkg::ValueMin;
      palette_o[7] = bc45_pkg::ValueMax;
    end
  end

endmodule

/* sv/bc45_pixel.sv */
// Looks up one pixel in both palettes and maps the channels by mode.
`timescale 1ns / 1ps

module bc45_pixel (
  input  bc45_pkg::palette_t                 pal0_i,
  input  bc45_pkg::palette_t                 pal1_i,
  input  logic [bc45_pkg::IndexWordBits-1:0] idx0_i,
  input  logic [bc45_pkg::IndexWordBits-1:0] idx1_i,
  input  logic [bc45_pkg::PixNumBits-1:0]    cnt_i,
  input  logic                               two_mode_i,
  output bc45_pkg::pixel_t                   pixel_o
);

  logic [5:0]                       shift;
  logic [bc45_pkg::IndexBits-1:0]   sel0;
  logic [bc45_pkg::IndexBits-1:0]   sel1;
  logic [bc45_pkg::ValueBits-1:0]   val0;
  logic [bc45_pkg::ValueBits-1:0]   val1;

  // Extract the 3-bit indices of the current pixel
  assign shift = {cnt_i, 1'b0} + 6'(cnt_i);
  assign sel0  = idx0_i[shift +: bc45_pkg::IndexBits];
  assign sel1  = idx1_i[shift +: bc45_pkg::IndexBits];
  assign val0  = pal0_i[sel0];
  assign val1  = pal1_i[sel1];

  // Route channels: gray copies the first channel, red/green zeroes blue
  always_comb begin
    pixel_o.red_value    = val0;
    pixel_o.pixel_number = cnt_i;
    pixel_o.last_pixel   = (cnt_i == bc45_pkg::LastPixel);
    if (two_mode_i) begin
      pixel_o.green_value = val1;
      pixel_o.blue_value  = bc45_pkg::ValueMin;
    end else begin
      pixel_o.green_value = val0;
      pixel_o.blue_value  = val0;
    end
  end

endmodule

/* sv/bc45_top_unused_guard.sv */
// Output register stage that holds one decoded pixel until the sink takes it.
`timescale 1ns / 1ps

module bc45_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  bc45_pkg::pixel_t pixel_i,
  input  logic             take_i,
  output logic             valid_o,
  output bc45_pkg::pixel_t pixel_o
);

  logic             valid_d, valid_q;
  bc45_pkg::pixel_t pixel_q;

  // Set on load, clear when taken without a new load
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture payload on load
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pixel_q <= pixel_i;
    end
  end

  assign valid_o = valid_q;
  assign pixel_o = pixel_q;

endmodule

/* sv/bc4_bc5_block_decode.sv */
// Top level of the BC4/BC5 block decoder.
`timescale 1ns / 1ps

// Decodes one compressed 4x4 block per input transaction into sixteen pixel
// transactions in raster order, the last one flagged. Palettes are built while
// the block is registered; one pixel per cycle is looked up into an output
// register while it is free or the sink is ready. The first pixel is offered
// once the block registers, then the output register, are loaded. The next
// block is accepted in the cycle that moves the sixteenth pixel into the output
// register, so with an always-ready sink pixels stream at one per cycle.
// Write the mode register (bit 0: 0 gray, 1 red/green) only while idle.
module bc4_bc5_block_decode (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  bc45_in_if.sink    in_i,
  bc45_out_if.source out_o
);

  logic                               two_mode_q;
  logic                               busy_q, busy_d;
  logic [bc45_pkg::PixNumBits-1:0]    cnt_q, cnt_d;
  bc45_pkg::palette_t                 pal0_q, pal1_q;
  bc45_pkg::palette_t                 pal0_d, pal1_d;
  logic [bc45_pkg::IndexWordBits-1:0] idx0_q, idx1_q;

  logic             in_fire;
  logic             emit;
  logic             emit_last;
  logic             out_valid;
  bc45_pkg::pixel_t pixel_d;
  bc45_pkg::pixel_t pixel_q;

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      two_mode_q <= bc45_pkg::ModeReset;
    end else if (cfg_we_i) begin
      two_mode_q <= cfg_wdata_i;
    end
  end

  // Palettes from the incoming block
  bc45_palette u_pal0 (
    .ep0_i     (in_i.first_half[7:0]),
    .ep1_i     (in_i.first_half[15:8]),
    .palette_o (pal0_d)
  );

  bc45_palette u_pal1 (
    .ep0_i     (in_i.second_half[7:0]),
    .ep1_i     (in_i.second_half[15:8]),
    .palette_o (pal1_d)
  );

  // Advance a pixel whenever the output register is free or being drained
  assign emit      = busy_q && (!out_valid || out_o.ready);
  assign emit_last = emit && (cnt_q == bc45_pkg::LastPixel);
  assign in_i.ready = !busy_q || emit_last;
  assign in_fire   = in_i.valid && in_i.ready;

  // Block sequencing
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (emit) begin
      cnt_d = cnt_q + 4'd1;
      if (emit_last) begin
        busy_d = 1'b0;
      end
    end
    if (in_fire) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold the current block's palettes and index words
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pal0_q <= pal0_d;
      pal1_q <= pal1_d;
      idx0_q <= in_i.first_half[bc45_pkg::HalfBits-1:16];
      idx1_q <= in_i.second_half[bc45_pkg::HalfBits-1:16];
    end
  end

  // Pixel lookup
  bc45_pixel u_pixel (
    .pal0_i     (pal0_q),
    .pal1_i     (pal1_q),
    .idx0_i     (idx0_q),
    .idx1_i     (idx1_q),
    .cnt_i      (cnt_q),
    .two_mode_i (two_mode_q),
    .pixel_o    (pixel_d)
  );

  // Output register
  bc45_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (emit),
    .pixel_i (pixel_d),
    .take_i  (out_o.ready),
    .valid_o (out_valid),
    .pixel_o (pixel_q)
  );

  assign out_o.valid        = out_valid;
  assign out_o.red_value    = pixel_q.red_value;
  assign out_o.green_value  = pixel_q.green_value;
  assign out_o.blue_value   = pixel_q.blue_value;
  assign out_o.pixel_number = pixel_q.pixel_number;
  assign out_o.last_pixel   = pixel_q.last_pixel;

  // A new block is never taken in the middle of the current one
  a_no_midblock_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !emit_last) |-> !in_i.ready)
    else $error("block accepted while pixels remain");

  // An accepted block starts at pixel zero
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (busy_q && cnt_q == '0))
    else $error("accepted block did not start at pixel zero");

  // Finishing the last pixel with no new block leaves the decoder idle
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_last && !in_fire) |=> !busy_q)
    else $error("decoder still busy after last pixel");

  // Gray mode copies one value to all three channels
  a_gray_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !two_mode_q) |->
      (out_o.red_value == out_o.green_value && out_o.green_value == out_o.blue_value))
    else $error("gray pixel channels differ");

endmodule

/* test/testbench.sv */
// Self-checking testbench for the BC4/BC5 block decoder with its own palette predictor.
`timescale 1ns / 1ps

module testbench;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  bc45_in_if  blk_if ();
  bc45_out_if pix_if ();

  bc4_bc5_block_decode dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (blk_if),
    .out_o       (pix_if)
  );

  // Predicted pixels in arrival order, and the mode as last written
  bc45_pkg::pixel_t pending_pixels[$];
  logic             two_channel;
  int               mismatch_count;
  bit               sender_idles;
  bit               sink_stalls;

  // Generate the clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Build one channel's eight-entry palette from its two endpoints
  function automatic bc45_pkg::palette_t expand_endpoints(
      input logic [bc45_pkg::HalfBits-1:0] half);
    bc45_pkg::palette_t pal;
    int unsigned        e0;
    int unsigned        e1;
    e0 = 32'(half[7:0]);
    e1 = 32'(half[15:8]);
    pal[0] = half[7:0];
    pal[1] = half[15:8];
    if (e0 > e1) begin
      for (int unsigned k = 1; k <= 6; k++) begin
        pal[k+1] = 8'((e0 * (7 - k) + e1 * k) / 7);
      end
    end else begin
      for (int unsigned k = 1; k <= 4; k++) begin
        pal[k+1] = 8'((e0 * (5 - k) + e1 * k) / 5);
      end
      pal[6] = bc45_pkg::ValueMin;
      pal[7] = bc45_pkg::ValueMax;
    end
    return pal;
  endfunction

  // Predict the sixteen pixels of one accepted block
  function automatic void predict_block(input logic [bc45_pkg::HalfBits-1:0] first_half,
                                        input logic [bc45_pkg::HalfBits-1:0] second_half);
    bc45_pkg::palette_t red_pal;
    bc45_pkg::palette_t green_pal;
    bc45_pkg::pixel_t   px;
    logic [2:0]         red_idx;
    logic [2:0]         green_idx;
    red_pal   = expand_endpoints(first_half);
    green_pal = expand_endpoints(second_half);
    for (int p = 0; p < bc45_pkg::PixelsPerBlock; p++) begin
      red_idx   = first_half[16 + 3*p +: 3];
      green_idx = second_half[16 + 3*p +: 3];
      px.red_value = red_pal[red_idx];
      if (two_channel) begin
        px.green_value = green_pal[green_idx];
        px.blue_value  = bc45_pkg::ValueMin;
      end else begin
        px.green_value = red_pal[red_idx];
        px.blue_value  = red_pal[red_idx];
      end
      px.pixel_number = 4'(p);
      px.last_pixel   = (4'(p) == bc45_pkg::LastPixel);
      pending_pixels.push_back(px);
    end
  endfunction

  // Index word where pixel p selects entry (p + start) mod 8
  function automatic logic [bc45_pkg::IndexWordBits-1:0] ramp_indices(
      input int unsigned start);
    logic [bc45_pkg::IndexWordBits-1:0] word;
    word = '0;
    for (int p = 0; p < bc45_pkg::PixelsPerBlock; p++) begin
      word[3*p +: 3] = 3'((p + start) % 8);
    end
    return word;
  endfunction

  // Random half, biased toward equal and extreme endpoints
  function automatic logic [bc45_pkg::HalfBits-1:0] random_half();
    logic [7:0]                         e0;
    logic [7:0]                         e1;
    logic [bc45_pkg::IndexWordBits-1:0] idx;
    idx = bc45_pkg::IndexWordBits'({$urandom, $urandom});
    e0  = 8'($urandom);
    e1  = 8'($urandom);
    case ($urandom_range(0, 7))
      0: e1 = e0;
      1: e0 = bc45_pkg::ValueMax;
      2: e1 = bc45_pkg::ValueMax;
      3: e0 = bc45_pkg::ValueMin;
      4: e1 = bc45_pkg::ValueMin;
      default: ;
    endcase
    return {idx, e1, e0};
  endfunction

  // Print one mismatch line and count it
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Compare each pixel transaction with the oldest prediction
  always @(posedge clk_i) begin
    bc45_pkg::pixel_t want;
    if (rst_ni === 1'b1 && pix_if.valid === 1'b1 && pix_if.ready === 1'b1) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel %0d", pix_if.pixel_number));
      end else begin
        want = pending_pixels.pop_front();
        if (pix_if.red_value !== want.red_value)
          report_mismatch($sformatf("red got %0d want %0d",
                                    pix_if.red_value, want.red_value));
        if (pix_if.green_value !== want.green_value)
          report_mismatch($sformatf("green got %0d want %0d",
                                    pix_if.green_value, want.green_value));
        if (pix_if.blue_value !== want.blue_value)
          report_mismatch($sformatf("blue got %0d want %0d",
                                    pix_if.blue_value, want.blue_value));
        if (pix_if.pixel_number !== want.pixel_number)
          report_mismatch($sformatf("pixel number got %0d want %0d",
                                    pix_if.pixel_number, want.pixel_number));
        if (pix_if.last_pixel !== want.last_pixel)
          report_mismatch($sformatf("last flag got %0b want %0b at pixel %0d",
                                    pix_if.last_pixel, want.last_pixel,
                                    want.pixel_number));
      end
    end
  end

  // Stall the pixel sink at random when enabled
  always @(posedge clk_i) begin
    pix_if.ready <= sink_stalls ? ($urandom_range(0, 99) >= 36) : 1'b1;
  end

  // Offer one block and hold it until accepted; valid stays high afterwards
  task automatic send_block(input logic [bc45_pkg::HalfBits-1:0] first_half,
                            input logic [bc45_pkg::HalfBits-1:0] second_half);
    while (sender_idles && $urandom_range(0, 99) < 36) begin
      blk_if.valid       <= 1'b0;
      blk_if.first_half  <= {$urandom, $urandom};
      blk_if.second_half <= {$urandom, $urandom};
      @(posedge clk_i);
    end
    blk_if.valid       <= 1'b1;
    blk_if.first_half  <= first_half;
    blk_if.second_half <= second_half;
    do @(posedge clk_i); while (blk_if.ready !== 1'b1);
    predict_block(first_half, second_half);
  endtask

  // Withdraw the offer after the last block of a sequence
  task automatic drop_valid();
    blk_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until every predicted pixel has arrived
  task automatic wait_drained();
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  // Write the mode register while the decoder is idle
  task automatic write_mode(input logic mode);
    drop_valid();
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    two_channel = mode;
  endtask

  // Extreme, equal and minimal endpoint pairs with every index value
  task automatic test_directed_blocks();
    send_block({ramp_indices(0), 8'd0, 8'd255}, {ramp_indices(5), 8'd255, 8'd0});
    send_block({ramp_indices(3), 8'd255, 8'd0}, {ramp_indices(1), 8'd0, 8'd255});
    send_block({ramp_indices(1), 8'd128, 8'd128}, {ramp_indices(7), 8'd37, 8'd37});
    send_block({ramp_indices(2), 8'd0, 8'd0}, {ramp_indices(4), 8'd255, 8'd255});
    send_block({ramp_indices(6), 8'd0, 8'd1}, {ramp_indices(2), 8'd1, 8'd0});
    send_block({ramp_indices(4), 8'd1, 8'd0}, {ramp_indices(6), 8'd0, 8'd1});
    send_block({bc45_pkg::HalfBits{1'b1}}, {bc45_pkg::HalfBits{1'b0}});
    send_block({bc45_pkg::HalfBits{1'b0}}, {bc45_pkg::HalfBits{1'b1}});
    drop_valid();
  endtask

  // Random blocks with idling on both sides
  task automatic test_random_blocks(input int count);
    repeat (count) send_block(random_half(), random_half());
    drop_valid();
  endtask

  // Random blocks at full rate with no idling anywhere
  task automatic test_full_rate_blocks(input int count);
    drop_valid();
    wait_drained();
    sender_idles = 1'b0;
    sink_stalls  = 1'b0;
    repeat (count) send_block(random_half(), random_half());
    drop_valid();
    sender_idles = 1'b1;
    sink_stalls  = 1'b1;
  endtask

  // Single blocks, each drained before the next is offered
  task automatic test_isolated_blocks(input int count);
    repeat (count) begin
      send_block(random_half(), random_half());
      drop_valid();
      wait_drained();
    end
  endtask

  // Run the tests in turn
  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= 1'b0;
    blk_if.valid       <= 1'b0;
    blk_if.first_half  <= '0;
    blk_if.second_half <= '0;
    two_channel    = bc45_pkg::ModeReset;
    mismatch_count = 0;
    sender_idles   = 1'b1;
    sink_stalls    = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_blocks();
    write_mode(1'b0);
    test_directed_blocks();
    test_random_blocks(100);
    write_mode(1'b1);
    test_random_blocks(100);
    test_full_rate_blocks(50);
    write_mode(1'b0);
    test_isolated_blocks(30);

    drop_valid();
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
